[rtl/core/hsl_to_rgb_converter_assert.svh]
// ----------------------------------------------------------------------------
// HSL to RGB converter assertion macros
// Shared property macros for the concurrent checks of the converter pipeline.
// ----------------------------------------------------------------------------
`ifndef HSL_TO_RGB_CONVERTER_ASSERT_SVH
`define HSL_TO_RGB_CONVERTER_ASSERT_SVH

// The condition must hold in the same cycle as the trigger.
`define H2R_ASSERT_IMPL(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("hsl_to_rgb_converter: same-cycle check failed");

// The condition must hold in the cycle after the trigger.
`define H2R_ASSERT_NEXT(label, clk, rst, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("hsl_to_rgb_converter: next-cycle check failed");

`endif

[rtl/core/h2r_pkg.sv]
// ----------------------------------------------------------------------------
// HSL to RGB converter package
// Types used by the converter top level and its channel ramp units.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package h2r_pkg;

  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HOLD,
    SEG_FALL,
    SEG_LOW
  } seg_t;

  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
    logic s6;
  } stage_en_t;

endpackage

`default_nettype wire

[rtl/core/h2r_channel.sv]
// ----------------------------------------------------------------------------
// HSL to RGB channel ramp
// Hue segment decode, ramp multiply, blend and byte scaling for one channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module h2r_channel #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                   clk,
  input  wire h2r_pkg::stage_en_t     en,
  input  wire logic [FRAC_BITS-1:0]   t1,
  input  wire logic [FRAC_BITS:0]     span3,
  input  wire logic [FRAC_BITS:0]     p4,
  input  wire logic [FRAC_BITS:0]     q4,
  input  wire logic [FRAC_BITS:0]     l4,
  input  wire logic                   zero4,
  output logic [7:0]                  chan
);
  import h2r_pkg::*;

  localparam logic [FRAC_BITS+2:0] ONE_X  = (FRAC_BITS+3)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS+2:0] FOUR_X = (FRAC_BITS+3)'(4) << FRAC_BITS;
  localparam logic [FRAC_BITS+1:0] TWO_Y  = (FRAC_BITS+2)'(2) << FRAC_BITS;

  logic [FRAC_BITS+1:0]   three_t;
  logic [FRAC_BITS+2:0]   six_t;
  logic [FRAC_BITS+2:0]   fall_f;
  seg_t                   seg_next;
  logic [FRAC_BITS:0]     f_next;

  seg_t                   seg2;
  logic [FRAC_BITS:0]     f2;
  seg_t                   seg3;
  logic [FRAC_BITS:0]     f3;
  seg_t                   seg4;
  logic [2*FRAC_BITS+1:0] prod4;
  logic [FRAC_BITS:0]     v_next;
  logic [FRAC_BITS:0]     v5;
  logic [FRAC_BITS+8:0]   scaled;
  logic [8:0]             c9;

  assign three_t = {2'b00, t1} + {1'b0, t1, 1'b0};
  assign six_t   = {three_t, 1'b0};
  assign fall_f  = FOUR_X - six_t;

  always_comb begin
    seg_next = SEG_LOW;
    f_next   = '0;
    priority if (six_t < ONE_X) begin
      seg_next = SEG_RISE;
      f_next   = six_t[FRAC_BITS:0];
    end else if (!t1[FRAC_BITS-1]) begin
      seg_next = SEG_HOLD;
    end else if (three_t < TWO_Y) begin
      seg_next = SEG_FALL;
      f_next   = fall_f[FRAC_BITS:0];
    end else begin
      seg_next = SEG_LOW;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      seg2 <= seg_next;
      f2   <= f_next;
    end
    if (en.s3) begin
      seg3 <= seg2;
      f3   <= f2;
    end
    if (en.s4) begin
      seg4  <= seg3;
      prod4 <= span3 * f3;
    end
  end

  always_comb begin
    v_next = p4;
    if (zero4) begin
      v_next = l4;
    end else begin
      unique case (seg4)
        SEG_RISE: v_next = p4 + prod4[2*FRAC_BITS:FRAC_BITS];
        SEG_HOLD: v_next = q4;
        SEG_FALL: v_next = p4 + prod4[2*FRAC_BITS:FRAC_BITS];
        SEG_LOW:  v_next = p4;
        default:  v_next = p4;
      endcase
    end
  end

  assign scaled = {v5, 8'b0} - {8'b0, v5};
  assign c9     = scaled[FRAC_BITS+8:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (en.s5) begin
      v5 <= v_next;
    end
    if (en.s6) begin
      chan <= (c9 > 9'd255) ? 8'hFF : c9[7:0];
    end
  end

endmodule

`default_nettype wire

[rtl/core/hsl_to_rgb_converter.sv]
// An accepted request moves through six register stages that advance independently.
// Throughput: one request per cycle while the output is not stalled.
// A stall at the output holds the full stages and lets bubbles close up behind them.
// Reset clears the stage valid bits only; no data register is reset.
// ----------------------------------------------------------------------------
// HSL to RGB converter
// Six-stage pipeline turning fixed-point hue, saturation and lightness into
// 8-bit red, green and blue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "hsl_to_rgb_converter_assert.svh"

module hsl_to_rgb_converter #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [FRAC_BITS-1:0] hue,
  input  wire logic [FRAC_BITS:0]   saturation,
  input  wire logic [FRAC_BITS:0]   lightness,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                red,
  output logic [7:0]                green,
  output logic [7:0]                blue
);
  import h2r_pkg::*;

  localparam logic [FRAC_BITS:0]   ONE   = (FRAC_BITS+1)'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS-1:0] THIRD = FRAC_BITS'((2 ** FRAC_BITS) / 3);

  logic [6:1]             vld;
  stage_en_t              en;
  logic                   en1;

  logic [FRAC_BITS:0]     s_c;
  logic [FRAC_BITS:0]     l_c;
  logic [2*FRAC_BITS+1:0] ls_full;

  logic [FRAC_BITS:0]     s1;
  logic [FRAC_BITS:0]     l1;
  logic [FRAC_BITS:0]     ls1;
  logic                   zero1;
  logic [FRAC_BITS-1:0]   t_r1;
  logic [FRAC_BITS-1:0]   t_g1;
  logic [FRAC_BITS-1:0]   t_b1;

  logic [FRAC_BITS+1:0]   q_raw;
  logic [FRAC_BITS:0]     q2;
  logic [FRAC_BITS:0]     l2;
  logic                   zero2;

  logic [FRAC_BITS+1:0]   l2x;
  logic [FRAC_BITS+1:0]   q2e;
  logic [FRAC_BITS+1:0]   q2x;
  logic [FRAC_BITS+1:0]   pc;
  logic [FRAC_BITS+1:0]   sp_diff;
  logic [FRAC_BITS:0]     p_next;
  logic [FRAC_BITS:0]     span_next;

  logic [FRAC_BITS:0]     p3;
  logic [FRAC_BITS:0]     q3;
  logic [FRAC_BITS:0]     span3;
  logic [FRAC_BITS:0]     l3;
  logic                   zero3;

  logic [FRAC_BITS:0]     p4;
  logic [FRAC_BITS:0]     q4;
  logic [FRAC_BITS:0]     l4;
  logic                   zero4;
  logic                   zero5;
  logic                   zero6;

  assign en.s6    = !vld[6] || out_ready;
  assign en.s5    = !vld[5] || en.s6;
  assign en.s4    = !vld[4] || en.s5;
  assign en.s3    = !vld[3] || en.s4;
  assign en.s2    = !vld[2] || en.s3;
  assign en1      = !vld[1] || en.s2;
  assign in_ready = en1;
  assign out_valid = vld[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en1)   vld[1] <= in_valid;
      if (en.s2) vld[2] <= vld[1];
      if (en.s3) vld[3] <= vld[2];
      if (en.s4) vld[4] <= vld[3];
      if (en.s5) vld[5] <= vld[4];
      if (en.s6) vld[6] <= vld[5];
    end
  end

  assign s_c     = (saturation > ONE) ? ONE : saturation;
  assign l_c     = (lightness > ONE) ? ONE : lightness;
  assign ls_full = l_c * s_c;

  always_ff @(posedge clk) begin
    if (en1) begin
      s1    <= s_c;
      l1    <= l_c;
      ls1   <= ls_full[2*FRAC_BITS:FRAC_BITS];
      zero1 <= (s_c == '0);
      t_r1  <= hue + THIRD;
      t_g1  <= hue;
      t_b1  <= hue - THIRD;
    end
  end

  always_comb begin
    if (l1[FRAC_BITS:FRAC_BITS-1] == 2'b00) begin
      q_raw = {1'b0, l1} + {1'b0, ls1};
    end else begin
      q_raw = {1'b0, l1} + {1'b0, s1} - {1'b0, ls1};
    end
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      q2    <= (q_raw > {1'b0, ONE}) ? ONE : q_raw[FRAC_BITS:0];
      l2    <= l1;
      zero2 <= zero1;
    end
  end

  assign l2x     = {l2, 1'b0};
  assign q2e     = {1'b0, q2};
  assign q2x     = {q2, 1'b0};
  assign pc      = l2x - q2e;
  assign sp_diff = q2x - l2x;

  always_comb begin
    p_next    = '0;
    span_next = q2;
    if (l2x > q2e) begin
      if (pc > q2e) begin
        p_next    = q2;
        span_next = '0;
      end else begin
        p_next    = pc[FRAC_BITS:0];
        span_next = sp_diff[FRAC_BITS:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      p3    <= p_next;
      q3    <= q2;
      span3 <= span_next;
      l3    <= l2;
      zero3 <= zero2;
    end
    if (en.s4) begin
      p4    <= p3;
      q4    <= q3;
      l4    <= l3;
      zero4 <= zero3;
    end
    if (en.s5) begin
      zero5 <= zero4;
    end
    if (en.s6) begin
      zero6 <= zero5;
    end
  end

  h2r_channel #(.FRAC_BITS(FRAC_BITS)) u_red (
    .clk   (clk),
    .en    (en),
    .t1    (t_r1),
    .span3 (span3),
    .p4    (p4),
    .q4    (q4),
    .l4    (l4),
    .zero4 (zero4),
    .chan  (red)
  );

  h2r_channel #(.FRAC_BITS(FRAC_BITS)) u_green (
    .clk   (clk),
    .en    (en),
    .t1    (t_g1),
    .span3 (span3),
    .p4    (p4),
    .q4    (q4),
    .l4    (l4),
    .zero4 (zero4),
    .chan  (green)
  );

  h2r_channel #(.FRAC_BITS(FRAC_BITS)) u_blue (
    .clk   (clk),
    .en    (en),
    .t1    (t_b1),
    .span3 (span3),
    .p4    (p4),
    .q4    (q4),
    .l4    (l4),
    .zero4 (zero4),
    .chan  (blue)
  );

  `H2R_ASSERT_NEXT(a_accept_fills, clk, rst, in_valid && in_ready, vld[1])
  `H2R_ASSERT_IMPL(a_q_le_one, clk, rst, vld[2], q2 <= ONE)
  `H2R_ASSERT_IMPL(a_p_le_q, clk, rst, vld[3], p3 <= q3)
  `H2R_ASSERT_IMPL(a_span_match, clk, rst, vld[3], span3 + p3 == q3)
  `H2R_ASSERT_IMPL(a_gray_out, clk, rst, vld[6] && zero6, red == green && green == blue)

endmodule

`default_nettype wire
